// File: sv/tts_pkg.sv
// Shared types and constants for the text terminal screen buffer.
// Used by the cell memory, the row map and the top level; no dependencies.
package tts_pkg;

    // One character cell, laid out as character, foreground, background, style.
    typedef struct packed {
        logic [7:0] ch;
        logic [3:0] fg;
        logic [3:0] bg;
        logic [7:0] style;
    } cell_t;

    localparam logic [7:0] BLANK_CHAR = 8'h20;

    localparam int CUR_COL_W = 7;
    localparam int CUR_ROW_W = 5;
    localparam int MAP_W     = 5;

    // Command kinds.
    localparam logic [3:0] KIND_PUT      = 4'd0;
    localparam logic [3:0] KIND_TAB      = 4'd1;
    localparam logic [3:0] KIND_FF       = 4'd2;
    localparam logic [3:0] KIND_MOVE     = 4'd3;
    localparam logic [3:0] KIND_CLR_LINE = 4'd4;
    localparam logic [3:0] KIND_CLR_SCR  = 4'd5;
    localparam logic [3:0] KIND_SCR_DN   = 4'd6;
    localparam logic [3:0] KIND_SCR_UP   = 4'd7;
    localparam logic [3:0] KIND_READ     = 4'd8;

    // Configuration register indexes.
    localparam logic [2:0] REG_WRAP   = 3'd0;
    localparam logic [2:0] REG_FG     = 3'd1;
    localparam logic [2:0] REG_BG     = 3'd2;
    localparam logic [2:0] REG_STYLE  = 3'd3;
    localparam logic [2:0] REG_TOP    = 3'd4;
    localparam logic [2:0] REG_BOTTOM = 3'd5;

    // Row map control from the sequencer.
    typedef struct packed {
        logic             rot_dn;
        logic             rot_up;
        logic [MAP_W-1:0] top;
        logic [MAP_W-1:0] bot;
        logic [MAP_W-1:0] lost;
    } map_ctl_t;

endpackage

// File: sv/tts_cell_ram.sv
// Cell store: one write port and one read port with registered read data.
// Depends on tts_pkg for the cell type.
module tts_cell_ram #(
    parameter int DEPTH = 1920,
    parameter int AW    = 11
) (
    input  logic                 aclk,
    input  logic                 we,
    input  logic [AW-1:0]        waddr,
    input  tts_pkg::cell_t       wdata,
    input  logic                 re,
    input  logic [AW-1:0]        raddr,
    output tts_pkg::cell_t       rdata
);

    tts_pkg::cell_t mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: sv/tts_row_map.sv
// Row map: screen line to physical line of the cell store, rotated on scrolls.
// Depends on tts_pkg for the control struct.
module tts_row_map #(
    parameter int ROWS = 24,
    parameter int LW   = 5
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  tts_pkg::map_ctl_t ctl,
    input  logic [LW-1:0]     look_line,
    output logic [LW-1:0]     look_phys
);

    logic [LW-1:0] map_reg  [ROWS];
    logic [LW-1:0] map_next [ROWS];
    logic [LW-1:0] below    [ROWS];
    logic [LW-1:0] above    [ROWS];

    assign look_phys = map_reg[look_line];

    for (genvar g = 0; g < ROWS; g++) begin : g_ent
        if (g == 0) begin : g_first
            assign below[g] = map_reg[g];
        end else begin : g_mid
            assign below[g] = map_reg[g-1];
        end
        if (g == ROWS - 1) begin : g_last
            assign above[g] = map_reg[g];
        end else begin : g_nlast
            assign above[g] = map_reg[g+1];
        end

        always_comb begin
            map_next[g] = map_reg[g];
            if (ctl.rot_dn) begin
                if (tts_pkg::MAP_W'(g) == ctl.bot) begin
                    map_next[g] = ctl.lost[LW-1:0];
                end else if (tts_pkg::MAP_W'(g) >= ctl.top && tts_pkg::MAP_W'(g) < ctl.bot) begin
                    map_next[g] = above[g];
                end
            end else if (ctl.rot_up) begin
                if (tts_pkg::MAP_W'(g) == ctl.top) begin
                    map_next[g] = ctl.lost[LW-1:0];
                end else if (tts_pkg::MAP_W'(g) > ctl.top && tts_pkg::MAP_W'(g) <= ctl.bot) begin
                    map_next[g] = below[g];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ROWS; i++) begin
                map_reg[i] <= LW'(i);
            end
        end else begin
            map_reg <= map_next;
        end
    end

endmodule

// File: sv/text_terminal_screen_buffer_core.sv
// Put, tab and move go from the execute state to the done state, or through a
// scroll when one is due; a cell read adds a read state between them. Clears and
// form feed walk the cell memory one cell per cycle through its one read port and
// one write port. A scroll latches the lost line, rotates the row map and blanks the new line. One item at a time.
// Reset is synchronous, active low; afterwards the block clears all ROWS*COLUMNS
// cells of the cell memory (1920 by default) before it takes the first item.
module text_terminal_screen_buffer_core #(
    parameter int COLUMNS   = 80,
    parameter int ROWS      = 24,
    parameter int TAB_WIDTH = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // char_code[7:0], col[15:8], row[23:16], scroll_at_edge[24], clear_backward[25]
    input  logic [31:0] s_axis_tdata,
    // kind[3:0]
    input  logic [3:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // cursor_col[6:0], cursor_row[11:7], cell_char[19:12], cell_fg[23:20],
    // cell_bg[27:24], cell_style[35:28]
    output logic [39:0] m_axis_tdata,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    localparam int CW = $clog2(COLUMNS);
    localparam int LW = $clog2(ROWS);
    localparam int NCELL = ROWS * COLUMNS;
    localparam int AW = $clog2(NCELL);
    localparam logic [CW-1:0] LAST_COL = CW'(COLUMNS - 1);
    localparam logic [LW-1:0] LAST_LINE = LW'(ROWS - 1);

    localparam logic [3:0] S_INIT  = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_EXEC  = 4'd2;
    localparam logic [3:0] S_SWEEP = 4'd3;
    localparam logic [3:0] S_READ  = 4'd4;
    localparam logic [3:0] S_LATCH = 4'd5;
    localparam logic [3:0] S_ROT   = 4'd6;
    localparam logic [3:0] S_DONE  = 4'd7;

    logic [3:0] state_reg, state_next;

    logic [3:0] kind_reg;
    logic [7:0] ch_reg, col_reg, row_reg;
    logic       edge_reg, back_reg;

    logic [CW-1:0] cur_col_reg, cur_col_next;
    logic [LW-1:0] cur_line_reg, cur_line_next;

    logic       wrap_reg;
    logic [3:0] fg_reg, bg_reg;
    logic [7:0] style_reg;
    logic [4:0] rtop_reg, rbot_reg;

    logic [LW-1:0] sw_line_reg, sw_line_next, end_line_reg, end_line_next;
    logic [CW-1:0] sw_col_reg, sw_col_next, end_col_reg, end_col_next;
    logic          rmw_reg, rmw_next;
    logic          pend_reg;
    logic [AW-1:0] pend_addr_reg;
    logic          dn_reg, dn_next;
    logic [LW-1:0] lost_reg, lost_next;

    tts_pkg::cell_t cell_reg, cell_next;
    logic           m_valid_reg, m_valid_next;
    logic [39:0]    m_data_reg, m_data_next;

    logic [LW-1:0] reg_t, reg_b;
    logic [LW-1:0] look_line, look_phys;
    logic [AW-1:0] look_addr;
    tts_pkg::map_ctl_t map_ctl;

    logic           ram_we, ram_re;
    logic [AW-1:0]  ram_waddr, ram_raddr;
    tts_pkg::cell_t ram_wdata, ram_rdata;

    logic [CW-1:0] tab_stop;
    logic          sweep_last, col_ok, row_ok;
    logic [LW-1:0] rowl;
    logic [CW-1:0] coll;

    // Effective scroll region.
    always_comb begin
        reg_t = (rtop_reg > 5'(ROWS - 1)) ? LAST_LINE : rtop_reg[LW-1:0];
        reg_b = (rbot_reg > 5'(ROWS - 1)) ? LAST_LINE : rbot_reg[LW-1:0];
        if (reg_b < reg_t) begin
            reg_b = reg_t;
        end
    end

    // Next tab stop: the smallest multiple of TAB_WIDTH above the cursor.
    always_comb begin
        tab_stop = LAST_COL;
        for (int k = COLUMNS / TAB_WIDTH; k >= 1; k--) begin
            if (k * TAB_WIDTH > int'(cur_col_reg)) begin
                tab_stop = CW'(k * TAB_WIDTH);
            end
        end
    end

    assign col_ok = col_reg < 8'(COLUMNS);
    assign row_ok = row_reg < 8'(ROWS);
    assign rowl = row_reg[LW-1:0];
    assign coll = col_reg[CW-1:0];
    assign sweep_last = (sw_line_reg == end_line_reg) && (sw_col_reg == end_col_reg);

    always_comb begin
        if (state_reg == S_EXEC && kind_reg == tts_pkg::KIND_READ) begin
            look_line = rowl;
        end else if (state_reg == S_EXEC) begin
            look_line = cur_line_reg;
        end else if (state_reg == S_LATCH) begin
            look_line = dn_reg ? reg_t : reg_b;
        end else begin
            look_line = sw_line_reg;
        end
    end

    always_comb begin
        if (state_reg == S_EXEC && kind_reg == tts_pkg::KIND_READ) begin
            look_addr = AW'(look_phys) * AW'(COLUMNS) + AW'(coll);
        end else if (state_reg == S_EXEC) begin
            look_addr = AW'(look_phys) * AW'(COLUMNS) + AW'(cur_col_reg);
        end else begin
            look_addr = AW'(look_phys) * AW'(COLUMNS) + AW'(sw_col_reg);
        end
    end

    always_comb begin
        map_ctl.rot_dn = (state_reg == S_ROT) && dn_reg;
        map_ctl.rot_up = (state_reg == S_ROT) && !dn_reg;
        map_ctl.top    = tts_pkg::MAP_W'(reg_t);
        map_ctl.bot    = tts_pkg::MAP_W'(reg_b);
        map_ctl.lost   = tts_pkg::MAP_W'(lost_reg);
    end

    tts_row_map #(.ROWS(ROWS), .LW(LW)) u_row_map (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (map_ctl),
        .look_line (look_line),
        .look_phys (look_phys)
    );

    // Memory port use. A pending blank from the previous sweep cycle is written
    // while the next cell of the sweep is read.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = look_addr;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = look_addr;
        if (pend_reg) begin
            ram_we    = 1'b1;
            ram_waddr = pend_addr_reg;
            ram_wdata = {tts_pkg::BLANK_CHAR, ram_rdata.fg, bg_reg, 8'd0};
        end else if ((state_reg == S_SWEEP || state_reg == S_INIT) && !rmw_reg) begin
            ram_we    = 1'b1;
            ram_wdata = {tts_pkg::BLANK_CHAR, 4'd0,
                         (state_reg == S_INIT) ? 4'd0 : bg_reg, 8'd0};
        end else if (state_reg == S_EXEC && kind_reg == tts_pkg::KIND_PUT) begin
            ram_we    = 1'b1;
            ram_wdata = {ch_reg, fg_reg, bg_reg, style_reg};
        end
        if (state_reg == S_SWEEP && rmw_reg) begin
            ram_re = 1'b1;
        end else if (state_reg == S_EXEC && kind_reg == tts_pkg::KIND_READ
                     && col_ok && row_ok) begin
            ram_re = 1'b1;
        end
    end

    tts_cell_ram #(.DEPTH(NCELL), .AW(AW)) u_cell_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        state_next    = state_reg;
        cur_col_next  = cur_col_reg;
        cur_line_next = cur_line_reg;
        sw_line_next  = sw_line_reg;
        sw_col_next   = sw_col_reg;
        end_line_next = end_line_reg;
        end_col_next  = end_col_reg;
        rmw_next      = rmw_reg;
        dn_next       = dn_reg;
        lost_next     = lost_reg;
        cell_next     = cell_reg;
        m_valid_next  = m_valid_reg && !m_axis_tready;
        m_data_next   = m_data_reg;

        unique case (state_reg) inside
            S_INIT, S_SWEEP: begin
                if (sweep_last) begin
                    state_next = (state_reg == S_INIT) ? S_IDLE : S_DONE;
                end else if (sw_col_reg == LAST_COL) begin
                    sw_col_next  = '0;
                    sw_line_next = sw_line_reg + 1'b1;
                end else begin
                    sw_col_next = sw_col_reg + 1'b1;
                end
            end
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                cell_next  = '0;
                state_next = S_DONE;
                rmw_next   = 1'b1;
                sw_col_next = '0;
                sw_line_next = '0;
                end_col_next = LAST_COL;
                end_line_next = LAST_LINE;
                case (kind_reg)
                    tts_pkg::KIND_PUT: begin
                        if (cur_col_reg >= LAST_COL) begin
                            if (wrap_reg) begin
                                cur_col_next = '0;
                                if (cur_line_reg < LAST_LINE) begin
                                    cur_line_next = cur_line_reg + 1'b1;
                                end else begin
                                    dn_next    = 1'b1;
                                    state_next = S_LATCH;
                                end
                            end
                        end else begin
                            cur_col_next = cur_col_reg + 1'b1;
                        end
                    end
                    tts_pkg::KIND_TAB: begin
                        if ({1'b0, cur_col_reg} < (CW + 1)'(COLUMNS - TAB_WIDTH)) begin
                            cur_col_next = tab_stop;
                        end else begin
                            cur_col_next = LAST_COL;
                        end
                    end
                    tts_pkg::KIND_FF: begin
                        cur_col_next  = '0;
                        cur_line_next = '0;
                        state_next    = S_SWEEP;
                    end
                    tts_pkg::KIND_MOVE: begin
                        if (col_reg == 8'd0) begin
                            cur_col_next = '0;
                        end else if (col_reg > 8'(COLUMNS)) begin
                            cur_col_next = LAST_COL;
                        end else begin
                            cur_col_next = CW'(col_reg - 8'd1);
                        end
                        if ({1'b0, row_reg} < 9'(reg_t) + 9'd1) begin
                            cur_line_next = reg_t;
                            if (edge_reg) begin
                                dn_next    = 1'b0;
                                state_next = S_LATCH;
                            end
                        end else if ({1'b0, row_reg} > 9'(reg_b) + 9'd1) begin
                            cur_line_next = reg_b;
                            if (edge_reg) begin
                                dn_next    = 1'b1;
                                state_next = S_LATCH;
                            end
                        end else begin
                            cur_line_next = LW'(row_reg - 8'd1);
                        end
                    end
                    tts_pkg::KIND_CLR_LINE: begin
                        if (row_ok && col_ok) begin
                            state_next   = S_SWEEP;
                            sw_line_next = rowl;
                            end_line_next = rowl;
                            if (back_reg) begin
                                end_col_next = coll;
                            end else begin
                                sw_col_next = coll;
                            end
                        end
                    end
                    tts_pkg::KIND_CLR_SCR: begin
                        if (row_ok) begin
                            if (!back_reg) begin
                                if (col_ok) begin
                                    state_next   = S_SWEEP;
                                    sw_line_next = rowl;
                                    sw_col_next  = coll;
                                end else if (rowl != LAST_LINE) begin
                                    state_next   = S_SWEEP;
                                    sw_line_next = rowl + 1'b1;
                                end
                            end else begin
                                if (col_ok) begin
                                    state_next    = S_SWEEP;
                                    end_line_next = rowl;
                                    end_col_next  = coll;
                                end else if (rowl != '0) begin
                                    state_next    = S_SWEEP;
                                    end_line_next = rowl - 1'b1;
                                end
                            end
                        end
                    end
                    tts_pkg::KIND_SCR_DN: begin
                        dn_next    = 1'b1;
                        state_next = S_LATCH;
                    end
                    tts_pkg::KIND_SCR_UP: begin
                        dn_next    = 1'b0;
                        state_next = S_LATCH;
                    end
                    tts_pkg::KIND_READ: begin
                        if (col_ok && row_ok) begin
                            state_next = S_READ;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_READ: begin
                cell_next  = ram_rdata;
                state_next = S_DONE;
            end
            S_LATCH: begin
                lost_next  = look_phys;
                state_next = S_ROT;
            end
            S_ROT: begin
                // The new line is written whole, so no read is needed.
                rmw_next      = 1'b0;
                sw_line_next  = dn_reg ? reg_b : reg_t;
                end_line_next = dn_reg ? reg_b : reg_t;
                sw_col_next   = '0;
                end_col_next  = LAST_COL;
                state_next    = S_SWEEP;
            end
            S_DONE: begin
                if (!m_valid_reg || m_axis_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {4'd0, cell_reg.style, cell_reg.bg, cell_reg.fg,
                                    cell_reg.ch, tts_pkg::CUR_ROW_W'(cur_line_reg),
                                    tts_pkg::CUR_COL_W'(cur_col_reg)};
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_INIT;
            cur_col_reg  <= '0;
            cur_line_reg <= '0;
            sw_line_reg  <= '0;
            sw_col_reg   <= '0;
            end_line_reg <= LAST_LINE;
            end_col_reg  <= LAST_COL;
            rmw_reg      <= 1'b0;
            pend_reg     <= 1'b0;
            dn_reg       <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cur_col_reg  <= cur_col_next;
            cur_line_reg <= cur_line_next;
            sw_line_reg  <= sw_line_next;
            sw_col_reg   <= sw_col_next;
            end_line_reg <= end_line_next;
            end_col_reg  <= end_col_next;
            rmw_reg      <= rmw_next;
            pend_reg     <= (state_reg == S_SWEEP) && rmw_reg;
            dn_reg       <= dn_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_addr_reg <= look_addr;
        lost_reg      <= lost_next;
        cell_reg      <= cell_next;
        m_data_reg    <= m_data_next;
        if (state_reg == S_IDLE && s_axis_tvalid) begin
            kind_reg <= s_axis_tuser;
            ch_reg   <= s_axis_tdata[7:0];
            col_reg  <= s_axis_tdata[15:8];
            row_reg  <= s_axis_tdata[23:16];
            edge_reg <= s_axis_tdata[24];
            back_reg <= s_axis_tdata[25];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wrap_reg  <= 1'b1;
            fg_reg    <= 4'd7;
            bg_reg    <= 4'd0;
            style_reg <= 8'd0;
            rtop_reg  <= 5'd0;
            rbot_reg  <= 5'd23;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                tts_pkg::REG_WRAP:   wrap_reg  <= cfg_data[0];
                tts_pkg::REG_FG:     fg_reg    <= cfg_data[3:0];
                tts_pkg::REG_BG:     bg_reg    <= cfg_data[3:0];
                tts_pkg::REG_STYLE:  style_reg <= cfg_data;
                tts_pkg::REG_TOP:    rtop_reg  <= cfg_data[4:0];
                tts_pkg::REG_BOTTOM: rbot_reg  <= cfg_data[4:0];
                default: begin
                end
            endcase
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

// File: sv/tts_checker.sv
// Port-level checks for the screen buffer core, attached with a bind.
// Depends only on the top level's ports.
module tts_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 24
) (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata
);

    // The clearing pass after reset holds off input.
    a_init_busy: assert property (@(posedge aclk) !aresetn |=> !s_axis_tready)
        else $error("input ready right after reset");

    // One item at a time: a transfer in closes the input side.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready again right after a transfer");

    a_cursor_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tdata[6:0] < COLUMNS) && (m_axis_tdata[11:7] < ROWS))
        else $error("cursor outside the screen");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind text_terminal_screen_buffer_core tts_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tts_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
